/* rtl/core/mme_pkg.sv */
`timescale 1ns / 1ps
// Shared types, constants and helpers for the matrix multiply engine.
// No dependencies; used by rtl/core/matrix_multiply_engine.sv.

package mme_pkg;

   localparam int MAX_DIM = 8;
   localparam int DIM_CAP = (MAX_DIM < 8) ? MAX_DIM : 8;
   localparam int DEPTH   = MAX_DIM * MAX_DIM;
   localparam int ADDR_W  = $clog2(DEPTH);

   localparam int IDX_W   = 3;
   localparam int DIM_W   = 4;
   localparam int KIND_W  = 2;
   localparam int CSR_W   = 2;
   localparam int VAL_W   = 16;
   localparam int PROD_W  = 2 * VAL_W;
   localparam int SUM_W   = 35;

   localparam logic [KIND_W-1:0] KIND_LOAD_A  = 2'd0;
   localparam logic [KIND_W-1:0] KIND_LOAD_B  = 2'd1;
   localparam logic [KIND_W-1:0] KIND_COMPUTE = 2'd2;

   localparam logic [CSR_W-1:0] CSR_A_ROWS = 2'd0;
   localparam logic [CSR_W-1:0] CSR_A_COLS = 2'd1;
   localparam logic [CSR_W-1:0] CSR_B_ROWS = 2'd2;
   localparam logic [CSR_W-1:0] CSR_B_COLS = 2'd3;

   localparam logic [DIM_W-1:0] DIM_RESET = DIM_W'(8);

   typedef logic [ADDR_W-1:0] addr_type;
   typedef logic [DIM_W-1:0]  dim_type;

   // clamp a dimension register to 1..DIM_CAP
   function automatic dim_type eff_dim(input dim_type reg_value);
      dim_type v;
      v = reg_value;
      if (v == '0) begin
         v = DIM_W'(1);
      end
      if (v > DIM_W'(DIM_CAP)) begin
         v = DIM_W'(DIM_CAP);
      end
      return v;
   endfunction

   function automatic addr_type mem_addr(input logic [IDX_W-1:0] r,
                                         input logic [IDX_W-1:0] c);
      return addr_type'(ADDR_W'(r) * ADDR_W'(MAX_DIM) + ADDR_W'(c));
   endfunction

endpackage

/* rtl/core/matrix_multiply_engine.sv */
`timescale 1ns / 1ps
// Matrix multiply engine top level: element stores, multiply-accumulate walk
// and result register. Depends on rtl/core/mme_pkg.sv.
//
// Usage:
//   req channel (valid/ready) carries load-A, load-B and compute transactions.
//   A load writes one 16-bit signed element into the A or B store in the cycle
//   it is accepted; loads outside the configured dimensions are dropped.
//   A compute walks the product row-major and returns one rsp transaction per
//   entry, last set on the final one; with A columns != B rows it returns a
//   single transaction with dim_error and last set.
//   csr port writes a_rows, a_cols, b_rows, b_cols (index 0..3); the user must
//   write these only while idle, as the block itself does not enforce it.
// Throughput: loads, one per cycle while idle. A compute walks the inner
//   dimension ac for each product entry through the single read port of each
//   store, which fetches one A and one B element per cycle into a two-stage
//   multiply and accumulate, then drains and emits the entry before the next.
//   A mismatch result skips the walk. req_ready is low for the whole compute walk.
// Reset: dimensions return to 8, stores keep their contents (undefined until
//   written), no transaction is pending.
// Stall: a finished entry waits in the rsp register; the walk holds until
//   rsp_ready frees it.

module matrix_multiply_engine (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_ready,
   input  logic [mme_pkg::KIND_W-1:0]        req_kind,
   input  logic [mme_pkg::IDX_W-1:0]         req_row,
   input  logic [mme_pkg::IDX_W-1:0]         req_col,
   input  logic signed [mme_pkg::VAL_W-1:0]  req_value,
   output logic                              rsp_valid,
   input  logic                              rsp_ready,
   output logic [mme_pkg::IDX_W-1:0]         rsp_out_row,
   output logic [mme_pkg::IDX_W-1:0]         rsp_out_col,
   output logic signed [mme_pkg::SUM_W-1:0]  rsp_sum,
   output logic                              rsp_last,
   output logic                              rsp_dim_error,
   input  logic                              csr_we,
   input  logic [mme_pkg::CSR_W-1:0]         csr_index,
   input  logic [mme_pkg::DIM_W-1:0]         csr_wdata
);

   typedef enum logic [1:0] {ST_IDLE, ST_RUN, ST_DRAIN, ST_EMIT} state_type;

   state_type                        state_ff;
   mme_pkg::dim_type                 a_rows_ff, a_cols_ff, b_rows_ff, b_cols_ff;
   mme_pkg::dim_type                 ar, ac, br, bc;

   logic signed [mme_pkg::VAL_W-1:0] a_mem [mme_pkg::DEPTH];
   logic signed [mme_pkg::VAL_W-1:0] b_mem [mme_pkg::DEPTH];
   logic signed [mme_pkg::VAL_W-1:0] a_rd_ff, b_rd_ff;
   mme_pkg::addr_type                waddr, a_raddr, b_raddr;
   logic                             a_we, b_we;

   logic [mme_pkg::IDX_W-1:0]        i_ff, j_ff, k_ff;
   logic                             err_ff;
   logic                             s1_valid_ff, s1_first_ff, s1_last_ff;
   logic                             s2_valid_ff, s2_first_ff, s2_last_ff;
   logic signed [mme_pkg::PROD_W-1:0] prod_ff;
   logic signed [mme_pkg::SUM_W-1:0] acc_ff, acc_in;
   logic                             sum_ready_ff;

   logic                             rsp_valid_ff;
   logic [mme_pkg::IDX_W-1:0]        rsp_row_ff, rsp_col_ff;
   logic signed [mme_pkg::SUM_W-1:0] rsp_sum_ff;
   logic                             rsp_last_ff, rsp_err_ff;

   logic                             req_fire, slot_free, k_last, j_last, i_last;
   logic                             entry_last;

   assign ar = mme_pkg::eff_dim(a_rows_ff);
   assign ac = mme_pkg::eff_dim(a_cols_ff);
   assign br = mme_pkg::eff_dim(b_rows_ff);
   assign bc = mme_pkg::eff_dim(b_cols_ff);

   assign req_ready = (state_ff == ST_IDLE);
   assign req_fire  = req_valid && req_ready;
   assign slot_free = !rsp_valid_ff || rsp_ready;

   assign k_last     = (mme_pkg::DIM_W'(k_ff) + mme_pkg::DIM_W'(1)) == ac;
   assign j_last     = (mme_pkg::DIM_W'(j_ff) + mme_pkg::DIM_W'(1)) == bc;
   assign i_last     = (mme_pkg::DIM_W'(i_ff) + mme_pkg::DIM_W'(1)) == ar;
   assign entry_last = err_ff || (i_last && j_last);

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         a_rows_ff <= mme_pkg::DIM_RESET;
         a_cols_ff <= mme_pkg::DIM_RESET;
         b_rows_ff <= mme_pkg::DIM_RESET;
         b_cols_ff <= mme_pkg::DIM_RESET;
      end else if (csr_we) begin
         case (csr_index)
            mme_pkg::CSR_A_ROWS: a_rows_ff <= csr_wdata;
            mme_pkg::CSR_A_COLS: a_cols_ff <= csr_wdata;
            mme_pkg::CSR_B_ROWS: b_rows_ff <= csr_wdata;
            mme_pkg::CSR_B_COLS: b_cols_ff <= csr_wdata;
            default: begin
            end
         endcase
      end
   end

   // element stores; writes only while idle, so reads of the walk never overlap them
   assign waddr   = mme_pkg::mem_addr(req_row, req_col);
   assign a_we    = req_fire && (req_kind == mme_pkg::KIND_LOAD_A)
                    && (mme_pkg::DIM_W'(req_row) < ar) && (mme_pkg::DIM_W'(req_col) < ac);
   assign b_we    = req_fire && (req_kind == mme_pkg::KIND_LOAD_B)
                    && (mme_pkg::DIM_W'(req_row) < br) && (mme_pkg::DIM_W'(req_col) < bc);
   assign a_raddr = mme_pkg::mem_addr(i_ff, k_ff);
   assign b_raddr = mme_pkg::mem_addr(k_ff, j_ff);

   always_ff @(posedge clock) begin
      if (a_we) begin
         a_mem[waddr] <= req_value;
      end
      a_rd_ff <= a_mem[a_raddr];
   end

   always_ff @(posedge clock) begin
      if (b_we) begin
         b_mem[waddr] <= req_value;
      end
      b_rd_ff <= b_mem[b_raddr];
   end

   // multiply-accumulate pipeline
   assign acc_in = (s2_first_ff ? '0 : acc_ff)
                   + {{(mme_pkg::SUM_W - mme_pkg::PROD_W){prod_ff[mme_pkg::PROD_W-1]}},
                      prod_ff};

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         s2_valid_ff  <= 1'b0;
         sum_ready_ff <= 1'b0;
      end else begin
         s1_valid_ff  <= (state_ff == ST_RUN);
         s2_valid_ff  <= s1_valid_ff;
         sum_ready_ff <= s2_valid_ff && s2_last_ff;
      end
      s1_first_ff <= (k_ff == '0);
      s1_last_ff  <= k_last;
      s2_first_ff <= s1_first_ff;
      s2_last_ff  <= s1_last_ff;
      prod_ff     <= a_rd_ff * b_rd_ff;
      if (s2_valid_ff) begin
         acc_ff <= acc_in;
      end
   end

   // walk sequencer and result register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
         err_ff       <= 1'b0;
         i_ff         <= '0;
         j_ff         <= '0;
         k_ff         <= '0;
      end else begin
         if ((state_ff == ST_EMIT) && slot_free) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
         case (state_ff)
            ST_IDLE: begin
               if (req_fire && (req_kind == mme_pkg::KIND_COMPUTE)) begin
                  i_ff   <= '0;
                  j_ff   <= '0;
                  k_ff   <= '0;
                  err_ff <= (ac != br);
                  state_ff <= (ac != br) ? ST_EMIT : ST_RUN;
               end
            end
            ST_RUN: begin
               if (k_last) begin
                  state_ff <= ST_DRAIN;
               end else begin
                  k_ff <= k_ff + 1'b1;
               end
            end
            ST_DRAIN: begin
               if (sum_ready_ff) begin
                  state_ff <= ST_EMIT;
               end
            end
            ST_EMIT: begin
               if (slot_free) begin
                  rsp_row_ff   <= err_ff ? '0 : i_ff;
                  rsp_col_ff   <= err_ff ? '0 : j_ff;
                  rsp_sum_ff   <= err_ff ? '0 : acc_ff;
                  rsp_last_ff  <= entry_last;
                  rsp_err_ff   <= err_ff;
                  k_ff         <= '0;
                  if (entry_last) begin
                     state_ff <= ST_IDLE;
                  end else begin
                     state_ff <= ST_RUN;
                     if (j_last) begin
                        j_ff <= '0;
                        i_ff <= i_ff + 1'b1;
                     end else begin
                        j_ff <= j_ff + 1'b1;
                     end
                  end
               end
            end
            default: state_ff <= ST_IDLE;
         endcase
      end
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_out_row   = rsp_row_ff;
   assign rsp_out_col   = rsp_col_ff;
   assign rsp_sum       = rsp_sum_ff;
   assign rsp_last      = rsp_last_ff;
   assign rsp_dim_error = rsp_err_ff;

   // no multiply in flight while new transactions are taken
   a_idle_pipe_empty: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_IDLE) |-> (!s1_valid_ff && !s2_valid_ff && !sum_ready_ff))
      else $error("pipeline busy while idle");

   // a finished sum only shows up while waiting for it
   a_sum_in_drain: assert property (@(posedge clock) disable iff (reset)
      sum_ready_ff |-> (state_ff == ST_DRAIN))
      else $error("sum ready outside drain");

   // a mismatch result is alone and empty
   a_err_result: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_err_ff) |-> (rsp_last_ff && (rsp_sum_ff == '0)))
      else $error("malformed dimension error result");

   // a new result is loaded only when the previous one has left
   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_EMIT && rsp_valid_ff && !rsp_ready) |=> (state_ff == ST_EMIT))
      else $error("result register overwritten");

endmodule

/* test/tb_matrix_multiply_engine.sv */
`timescale 1ns / 1ps
// Self-checking testbench for matrix_multiply_engine: drives load, compute and CSR traffic
// with random idling on both channels and checks every product entry against its own model.
// Depends on rtl/core/mme_pkg.sv and rtl/core/matrix_multiply_engine.sv.

module tb_matrix_multiply_engine;

   localparam logic [mme_pkg::KIND_W-1:0] KIND_UNUSED = 2'd3;
   localparam int unsigned CLOCK_HALF    = 6;
   localparam int unsigned ITEM_TARGET   = 100;
   localparam int unsigned SETTLE_CYCLES = 8;
   localparam int unsigned TAIL_CYCLES   = 20;
   localparam int unsigned CYCLE_LIMIT   = 500000;

   typedef struct {
      logic [mme_pkg::IDX_W-1:0]        row;
      logic [mme_pkg::IDX_W-1:0]        col;
      logic signed [mme_pkg::SUM_W-1:0] dot;
      logic                             last;
      logic                             dim_error;
   } product_entry_type;

   class product_checker_type;
      mme_pkg::dim_type                 dim_reg[4];
      logic signed [mme_pkg::VAL_W-1:0] a_mem[mme_pkg::DEPTH];
      logic signed [mme_pkg::VAL_W-1:0] b_mem[mme_pkg::DEPTH];
      bit                               a_written[mme_pkg::DEPTH];
      bit                               b_written[mme_pkg::DEPTH];
      product_entry_type                expected_entries[$];
      int unsigned                      errors;

      function new();
         foreach (dim_reg[n]) dim_reg[n] = mme_pkg::DIM_RESET;
         foreach (a_written[n]) begin
            a_written[n] = 0;
            b_written[n] = 0;
         end
         errors = 0;
      endfunction

      function void set_dim(logic [mme_pkg::CSR_W-1:0] idx, mme_pkg::dim_type data);
         dim_reg[idx] = data;
      endfunction

      function int dim(logic [mme_pkg::CSR_W-1:0] idx);
         int d;
         d = int'(dim_reg[idx]);
         if (d == 0) d = 1;
         if (d > mme_pkg::DIM_CAP) d = mme_pkg::DIM_CAP;
         return d;
      endfunction

      function int unsigned pending();
         return expected_entries.size();
      endfunction

      function void note_request(logic [mme_pkg::KIND_W-1:0] kind,
                                 logic [mme_pkg::IDX_W-1:0] row,
                                 logic [mme_pkg::IDX_W-1:0] col,
                                 logic signed [mme_pkg::VAL_W-1:0] data);
         int ar, ac, br, bc;
         longint acc;
         product_entry_type e;
         ar = dim(mme_pkg::CSR_A_ROWS);
         ac = dim(mme_pkg::CSR_A_COLS);
         br = dim(mme_pkg::CSR_B_ROWS);
         bc = dim(mme_pkg::CSR_B_COLS);
         case (kind)
            mme_pkg::KIND_LOAD_A: begin
               if (int'(row) < ar && int'(col) < ac) begin
                  a_mem[int'(row) * mme_pkg::MAX_DIM + int'(col)] = data;
                  a_written[int'(row) * mme_pkg::MAX_DIM + int'(col)] = 1;
               end
            end
            mme_pkg::KIND_LOAD_B: begin
               if (int'(row) < br && int'(col) < bc) begin
                  b_mem[int'(row) * mme_pkg::MAX_DIM + int'(col)] = data;
                  b_written[int'(row) * mme_pkg::MAX_DIM + int'(col)] = 1;
               end
            end
            mme_pkg::KIND_COMPUTE: begin
               if (ac != br) begin
                  e.row = '0;
                  e.col = '0;
                  e.dot = '0;
                  e.last = 1'b1;
                  e.dim_error = 1'b1;
                  expected_entries.insert(expected_entries.size(), e);
               end else begin
                  for (int i = 0; i < ar; i++) begin
                     for (int j = 0; j < bc; j++) begin
                        acc = 0;
                        for (int k = 0; k < ac; k++) begin
                           acc += longint'(a_mem[i * mme_pkg::MAX_DIM + k]) *
                                  longint'(b_mem[k * mme_pkg::MAX_DIM + j]);
                        end
                        e.row = mme_pkg::IDX_W'(i);
                        e.col = mme_pkg::IDX_W'(j);
                        e.dot = mme_pkg::SUM_W'(acc);
                        e.last = (i == ar - 1) && (j == bc - 1);
                        e.dim_error = 1'b0;
                        expected_entries.insert(expected_entries.size(), e);
                     end
                  end
               end
            end
            default: ;
         endcase
      endfunction

      function void check_entry(logic [mme_pkg::IDX_W-1:0] row,
                                logic [mme_pkg::IDX_W-1:0] col,
                                logic signed [mme_pkg::SUM_W-1:0] dot, logic last,
                                logic dim_error);
         product_entry_type e;
         if (expected_entries.size() == 0) begin
            $error("unexpected product entry: row %0d col %0d sum %0d", row, col, dot);
            errors++;
            return;
         end
         e = expected_entries.pop_front();
         if (row !== e.row) begin
            $error("out_row: expected %0d, actual %0d", e.row, row);
            errors++;
         end
         if (col !== e.col) begin
            $error("out_col: expected %0d, actual %0d", e.col, col);
            errors++;
         end
         if (dot !== e.dot) begin
            $error("sum: expected %0d, actual %0d", e.dot, dot);
            errors++;
         end
         if (last !== e.last) begin
            $error("last: expected %0d, actual %0d", e.last, last);
            errors++;
         end
         if (dim_error !== e.dim_error) begin
            $error("dim_error: expected %0d, actual %0d", e.dim_error, dim_error);
            errors++;
         end
      endfunction
   endclass

   logic                             clock = 1'b0;
   logic                             reset = 1'b1;
   logic                             req_valid = 1'b0;
   logic                             req_ready;
   logic [mme_pkg::KIND_W-1:0]       req_kind = mme_pkg::KIND_LOAD_A;
   logic [mme_pkg::IDX_W-1:0]        req_row = '0;
   logic [mme_pkg::IDX_W-1:0]        req_col = '0;
   logic signed [mme_pkg::VAL_W-1:0] req_value = '0;
   logic                             rsp_valid;
   logic                             rsp_ready = 1'b0;
   logic [mme_pkg::IDX_W-1:0]        rsp_out_row;
   logic [mme_pkg::IDX_W-1:0]        rsp_out_col;
   logic signed [mme_pkg::SUM_W-1:0] rsp_sum;
   logic                             rsp_last;
   logic                             rsp_dim_error;
   logic                             csr_we = 1'b0;
   logic [mme_pkg::CSR_W-1:0]        csr_index = mme_pkg::CSR_A_ROWS;
   logic [mme_pkg::DIM_W-1:0]        csr_wdata = '0;

   product_checker_type sb;
   int unsigned    req_pct = 0;
   int unsigned    rsp_pct = 0;
   int unsigned    stall_left = 0;
   int unsigned    cycle_count = 0;
   int unsigned    sent_count = 0;

   matrix_multiply_engine u_top (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_ready     (req_ready),
      .req_kind      (req_kind),
      .req_row       (req_row),
      .req_col       (req_col),
      .req_value     (req_value),
      .rsp_valid     (rsp_valid),
      .rsp_ready     (rsp_ready),
      .rsp_out_row   (rsp_out_row),
      .rsp_out_col   (rsp_out_col),
      .rsp_sum       (rsp_sum),
      .rsp_last      (rsp_last),
      .rsp_dim_error (rsp_dim_error),
      .csr_we        (csr_we),
      .csr_index     (csr_index),
      .csr_wdata     (csr_wdata)
   );

   always #CLOCK_HALF clock = ~clock;

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("CHECKS FAILED");
         $finish;
      end
   end

   function automatic int unsigned gap_len(int unsigned pct);
      if ($urandom_range(99) >= pct) return 0;
      if ($urandom_range(9) == 0) return $urandom_range(40, 10);
      return $urandom_range(3, 1);
   endfunction

   function automatic int unsigned pick_pct();
      case ($urandom_range(2))
         0: return 0;
         1: return 20;
         default: return 60;
      endcase
   endfunction

   function automatic logic signed [mme_pkg::VAL_W-1:0] pick_value();
      case ($urandom_range(9))
         0: return 16'sh8000;
         1: return 16'sh7fff;
         2: return -16'sd1;
         default: return mme_pkg::VAL_W'($urandom);
      endcase
   endfunction

   // several register codes map to the same effective size
   function automatic mme_pkg::dim_type encode_dim(int unsigned d);
      if (d == 1 && $urandom_range(1) == 0) return '0;
      if (d == mme_pkg::DIM_CAP && $urandom_range(1) == 0) begin
         return mme_pkg::DIM_W'($urandom_range(15, mme_pkg::DIM_CAP));
      end
      return mme_pkg::DIM_W'(d);
   endfunction

   always @(posedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
         stall_left = 0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            sb.check_entry(rsp_out_row, rsp_out_col, rsp_sum, rsp_last, rsp_dim_error);
         end
         if (stall_left != 0) begin
            rsp_ready <= 1'b0;
            stall_left--;
         end else begin
            rsp_ready <= 1'b1;
            stall_left = gap_len(rsp_pct);
         end
      end
   end

   task automatic send(logic [mme_pkg::KIND_W-1:0] kind, logic [mme_pkg::IDX_W-1:0] row,
                       logic [mme_pkg::IDX_W-1:0] col,
                       logic signed [mme_pkg::VAL_W-1:0] data);
      int unsigned gap;
      gap = gap_len(req_pct);
      if (gap != 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_kind  <= kind;
      req_row   <= row;
      req_col   <= col;
      req_value <= data;
      do @(posedge clock); while (!req_ready);
      sb.note_request(kind, row, col, data);
      sent_count++;
   endtask

   task automatic configure(mme_pkg::dim_type ar, mme_pkg::dim_type ac,
                            mme_pkg::dim_type br, mme_pkg::dim_type bc);
      mme_pkg::dim_type          vals[4];
      logic [mme_pkg::CSR_W-1:0] order[4];
      vals  = '{ar, ac, br, bc};
      order = '{mme_pkg::CSR_A_ROWS, mme_pkg::CSR_A_COLS,
                mme_pkg::CSR_B_ROWS, mme_pkg::CSR_B_COLS};
      for (int n = 0; n < 4; n++) begin
         csr_we    <= 1'b1;
         csr_index <= order[n];
         csr_wdata <= vals[n];
         sb.set_dim(order[n], vals[n]);
         @(posedge clock);
      end
      csr_we <= 1'b0;
   endtask

   task automatic drain();
      req_valid <= 1'b0;
      while (sb.pending() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // load every operand entry that a compute will read and that was never written
   task automatic fill_operands();
      int ar, ac, bc;
      ar = sb.dim(mme_pkg::CSR_A_ROWS);
      ac = sb.dim(mme_pkg::CSR_A_COLS);
      bc = sb.dim(mme_pkg::CSR_B_COLS);
      for (int i = 0; i < ar; i++) begin
         for (int k = 0; k < ac; k++) begin
            if (!sb.a_written[i * mme_pkg::MAX_DIM + k]) begin
               send(mme_pkg::KIND_LOAD_A, mme_pkg::IDX_W'(i), mme_pkg::IDX_W'(k),
                    pick_value());
            end
         end
      end
      for (int k = 0; k < ac; k++) begin
         for (int j = 0; j < bc; j++) begin
            if (!sb.b_written[k * mme_pkg::MAX_DIM + j]) begin
               send(mme_pkg::KIND_LOAD_B, mme_pkg::IDX_W'(k), mme_pkg::IDX_W'(j),
                    pick_value());
            end
         end
      end
   endtask

   initial begin
      int unsigned               phase_no;
      int unsigned               mode;
      int unsigned               pick;
      int unsigned               ar_e, ac_e, br_e, bc_e;
      logic [mme_pkg::IDX_W-1:0] r, c;

      sb = new();
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      configure(4'd2, 4'd2, 4'd2, 4'd2);
      send(mme_pkg::KIND_LOAD_A, 3'd0, 3'd0, 16'sh7fff);
      send(mme_pkg::KIND_LOAD_A, 3'd0, 3'd1, 16'sh8000);
      send(mme_pkg::KIND_LOAD_A, 3'd1, 3'd0, 16'sh8000);
      send(mme_pkg::KIND_LOAD_A, 3'd1, 3'd1, 16'sh7fff);
      send(mme_pkg::KIND_LOAD_B, 3'd0, 3'd0, 16'sh8000);
      send(mme_pkg::KIND_LOAD_B, 3'd0, 3'd1, 16'sh7fff);
      send(mme_pkg::KIND_LOAD_B, 3'd1, 3'd0, 16'sh8000);
      send(mme_pkg::KIND_LOAD_B, 3'd1, 3'd1, -16'sd1);
      send(mme_pkg::KIND_LOAD_A, 3'd7, 3'd7, 16'sh1234);
      send(mme_pkg::KIND_LOAD_B, 3'd2, 3'd0, 16'sh4321);
      send(KIND_UNUSED, 3'd7, 3'd7, -16'sd1);
      send(mme_pkg::KIND_COMPUTE, 3'd7, 3'd7, 16'sh7fff);

      drain();
      configure(4'd15, 4'd3, 4'd0, 4'd15);
      send(mme_pkg::KIND_COMPUTE, 3'd0, 3'd0, 16'sh0000);

      drain();
      configure(4'd1, 4'd0, 4'd0, 4'd1);
      send(mme_pkg::KIND_LOAD_A, 3'd0, 3'd0, 16'sh8000);
      send(mme_pkg::KIND_LOAD_B, 3'd0, 3'd0, 16'sh8000);
      send(mme_pkg::KIND_LOAD_A, 3'd0, 3'd1, 16'sh5555);
      send(mme_pkg::KIND_COMPUTE, 3'd5, 3'd2, -16'sd1);
      send(mme_pkg::KIND_COMPUTE, 3'd2, 3'd5, 16'sh0001);

      phase_no = 0;
      while (sent_count < ITEM_TARGET) begin
         mode = (phase_no == 0) ? 0 : $urandom_range(9);
         if (mode == 0) begin
            ar_e = mme_pkg::DIM_CAP;
            ac_e = 1;
            bc_e = mme_pkg::DIM_CAP;
         end else if (mode == 1) begin
            ar_e = $urandom_range(2, 1);
            ac_e = mme_pkg::DIM_CAP;
            bc_e = $urandom_range(2, 1);
         end else begin
            ar_e = $urandom_range(4, 1);
            ac_e = $urandom_range(4, 1);
            bc_e = $urandom_range(4, 1);
         end
         br_e = ac_e;
         if (phase_no != 0 && $urandom_range(4) == 0) begin
            br_e = (ac_e % mme_pkg::DIM_CAP) + 1;
         end

         drain();
         configure(encode_dim(ar_e), encode_dim(ac_e), encode_dim(br_e), encode_dim(bc_e));
         req_pct = pick_pct();
         rsp_pct = pick_pct();

         repeat ($urandom_range(12, 2)) begin
            pick = $urandom_range(99);
            if (pick < 45) begin
               r = ($urandom_range(9) < 7) ? mme_pkg::IDX_W'($urandom_range(ar_e - 1))
                                           : mme_pkg::IDX_W'($urandom);
               c = ($urandom_range(9) < 7) ? mme_pkg::IDX_W'($urandom_range(ac_e - 1))
                                           : mme_pkg::IDX_W'($urandom);
               send(mme_pkg::KIND_LOAD_A, r, c, pick_value());
            end else if (pick < 90) begin
               r = ($urandom_range(9) < 7) ? mme_pkg::IDX_W'($urandom_range(br_e - 1))
                                           : mme_pkg::IDX_W'($urandom);
               c = ($urandom_range(9) < 7) ? mme_pkg::IDX_W'($urandom_range(bc_e - 1))
                                           : mme_pkg::IDX_W'($urandom);
               send(mme_pkg::KIND_LOAD_B, r, c, pick_value());
            end else begin
               send(KIND_UNUSED, mme_pkg::IDX_W'($urandom), mme_pkg::IDX_W'($urandom),
                    pick_value());
            end
         end

         if (ac_e == br_e) fill_operands();
         send(mme_pkg::KIND_COMPUTE, mme_pkg::IDX_W'($urandom), mme_pkg::IDX_W'($urandom),
              pick_value());
         if ($urandom_range(3) == 0) begin
            send(mme_pkg::KIND_COMPUTE, mme_pkg::IDX_W'($urandom),
                 mme_pkg::IDX_W'($urandom), pick_value());
         end
         phase_no++;
      end

      drain();
      repeat (TAIL_CYCLES) @(posedge clock);
      if (sb.errors == 0 && sb.pending() == 0) begin
         $display("ALL CHECKS PASSED");
      end else begin
         $display("CHECKS FAILED");
      end
      $finish;
   end

endmodule
